// ----- rtl/vrx_pkg.sv -----
// Shared types and constants for the vertex rotation unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package vrx_pkg;

    localparam int COORD_WIDTH         = 32;
    localparam int TRIG_WIDTH          = 16;
    localparam int TRIG_FRAC_BITS_DEF  = 14;
    localparam int CFG_INDEX_WIDTH     = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] cos_x;
        logic signed [TRIG_WIDTH-1:0] sin_x;
        logic signed [TRIG_WIDTH-1:0] cos_y;
        logic signed [TRIG_WIDTH-1:0] sin_y;
        logic signed [TRIG_WIDTH-1:0] cos_z;
        logic signed [TRIG_WIDTH-1:0] sin_z;
    } trig_cfg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [COORD_WIDTH-1:0] z_in;
        logic                          last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          last_out;
    } result_t;

    // One plane rotation: p and q turn, r rides along untouched.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p;
        logic signed [COORD_WIDTH-1:0] q;
        logic signed [COORD_WIDTH-1:0] r;
        logic                          last;
    } rot_lane_t;

endpackage

`default_nettype wire

// ----- rtl/vertex_rotate_xyz_unit.sv -----
// Top level of the vertex rotation unit: config registers and three rotation stages.
// Depends on vrx_pkg, vrx_cfg_regs and vrx_rot_stage.
//
// Usage:
//   Input channel: drive vertex and raise start; the item is taken at any rising
//   edge with start high and busy low. busy is always low, so one vertex can be
//   taken every clock, with no gaps needed between items.
//   Each vertex is turned about X, then Y, then Z. Every rotation is a product
//   stage (four 32x16 multipliers) and a sum/round/saturate stage, so a result
//   appears on result with result_valid high for one cycle, when it reaches the
//   Z sum register. Throughput is one vertex per clock; results keep input order.
//   The receiver cannot stall: it must take each result in the cycle it is shown.
//   Config: cfg_wr_en writes cfg_wdata into register cfg_index at the clock edge
//   (0 cos X, 1 sin X, 2 cos Y, 3 sin Y, 4 cos Z, 5 sin Z; other indexes are
//   ignored). Write only while no item is in flight.
//   Reset: rst_n low empties the pipeline and sets every cosine to 1.0 and every
//   sine to 0, the identity rotation.
`default_nettype none

module vertex_rotate_xyz_unit #(
    parameter int TRIG_FRAC_BITS = vrx_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vrx_pkg::vertex_t                    vertex,
    output logic                                result_valid,
    output vrx_pkg::result_t                    result,
    input  logic                                cfg_wr_en,
    input  logic [vrx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vrx_pkg::TRIG_WIDTH-1:0]      cfg_wdata
);
    import vrx_pkg::*;

    trig_cfg_t cfg;
    logic      accept;
    rot_lane_t lane_x_in, lane_x_out;
    rot_lane_t lane_y_in, lane_y_out;
    rot_lane_t lane_z_in, lane_z_out;
    logic      valid_x, valid_y, valid_z;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    vrx_cfg_regs #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    // about X: (y, z) turn, x rides along
    always_comb
    begin
        lane_x_in.p    = vertex.y_in;
        lane_x_in.q    = vertex.z_in;
        lane_x_in.r    = vertex.x_in;
        lane_x_in.last = vertex.last_vertex;
    end

    vrx_rot_stage #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .lane_in   (lane_x_in),
        .cos_val   (cfg.cos_x),
        .sin_val   (cfg.sin_x),
        .out_valid (valid_x),
        .lane_out  (lane_x_out)
    );

    // about Y: (z, x) turn, so z' = c*z - s*x and x' = s*z + c*x
    always_comb
    begin
        lane_y_in.p    = lane_x_out.q;
        lane_y_in.q    = lane_x_out.r;
        lane_y_in.r    = lane_x_out.p;
        lane_y_in.last = lane_x_out.last;
    end

    vrx_rot_stage #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_x),
        .lane_in   (lane_y_in),
        .cos_val   (cfg.cos_y),
        .sin_val   (cfg.sin_y),
        .out_valid (valid_y),
        .lane_out  (lane_y_out)
    );

    // about Z: (x, y) turn, z rides along
    always_comb
    begin
        lane_z_in.p    = lane_y_out.q;
        lane_z_in.q    = lane_y_out.r;
        lane_z_in.r    = lane_y_out.p;
        lane_z_in.last = lane_y_out.last;
    end

    vrx_rot_stage #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_y),
        .lane_in   (lane_z_in),
        .cos_val   (cfg.cos_z),
        .sin_val   (cfg.sin_z),
        .out_valid (valid_z),
        .lane_out  (lane_z_out)
    );

    always_comb
    begin
        result.x_out    = lane_z_out.p;
        result.y_out    = lane_z_out.q;
        result.z_out    = lane_z_out.r;
        result.last_out = lane_z_out.last;
    end

    assign result_valid = valid_z;

endmodule

`default_nettype wire

// ----- rtl/vrx_cfg_regs.sv -----
// Cosine/sine configuration registers for the vertex rotation unit.
// Depends on vrx_pkg (trig_cfg_t, register index codes).
`default_nettype none

module vrx_cfg_regs #(
    parameter int TRIG_FRAC_BITS = vrx_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [vrx_pkg::CFG_INDEX_WIDTH-1:0]   index,
    input  logic [vrx_pkg::TRIG_WIDTH-1:0]        wdata,
    output vrx_pkg::trig_cfg_t                    cfg
);
    import vrx_pkg::*;

    localparam logic [31:0]           OneWide = 32'd1 << TRIG_FRAC_BITS;
    localparam logic [TRIG_WIDTH-1:0] TrigOne = OneWide[TRIG_WIDTH-1:0];

    trig_cfg_t cfg_reg;
    trig_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index_t'(index))
                REG_COS_X: cfg_next.cos_x = wdata;
                REG_SIN_X: cfg_next.sin_x = wdata;
                REG_COS_Y: cfg_next.cos_y = wdata;
                REG_SIN_Y: cfg_next.sin_y = wdata;
                REG_COS_Z: cfg_next.cos_z = wdata;
                REG_SIN_Z: cfg_next.sin_z = wdata;
                default:   cfg_next = cfg_reg;   // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_x <= TrigOne;
            cfg_reg.sin_x <= '0;
            cfg_reg.cos_y <= TrigOne;
            cfg_reg.sin_y <= '0;
            cfg_reg.cos_z <= TrigOne;
            cfg_reg.sin_z <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/vrx_rot_stage.sv -----
// One plane rotation, two register stages: products, then sum/round/saturate.
// Depends on vrx_pkg (rot_lane_t, widths).
`default_nettype none

module vrx_rot_stage #(
    parameter int TRIG_FRAC_BITS = vrx_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  vrx_pkg::rot_lane_t                   lane_in,
    input  logic signed [vrx_pkg::TRIG_WIDTH-1:0] cos_val,
    input  logic signed [vrx_pkg::TRIG_WIDTH-1:0] sin_val,
    output logic                                 out_valid,
    output vrx_pkg::rot_lane_t                   lane_out
);
    import vrx_pkg::*;

    localparam int ProdW = COORD_WIDTH + TRIG_WIDTH;
    localparam int SumW  = ProdW + 1;

    localparam logic signed [SumW-1:0] RoundBias = SumW'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [SumW-1:0] SatHi     = (SumW'(1) <<< (COORD_WIDTH - 1)) - SumW'(1);
    localparam logic signed [SumW-1:0] SatLo     = -(SumW'(1) <<< (COORD_WIDTH - 1));

    // round to nearest, ties up, then clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] round_sat(
        input logic signed [SumW-1:0] sum
    );
        logic signed [SumW-1:0] shifted;
        shifted = (sum + RoundBias) >>> TRIG_FRAC_BITS;
        if (shifted > SatHi)
            return SatHi[COORD_WIDTH-1:0];
        else if (shifted < SatLo)
            return SatLo[COORD_WIDTH-1:0];
        else
            return shifted[COORD_WIDTH-1:0];
    endfunction

    // product stage
    logic                          mul_valid_reg;
    logic signed [ProdW-1:0]       pc_reg, qs_reg, ps_reg, qc_reg;
    logic signed [ProdW-1:0]       pc_next, qs_next, ps_next, qc_next;
    logic signed [COORD_WIDTH-1:0] mul_r_reg;
    logic                          mul_last_reg;

    // sum stage
    logic                          sum_valid_reg;
    rot_lane_t                     sum_lane_reg;
    rot_lane_t                     sum_lane_next;
    logic signed [SumW-1:0]        sum_p, sum_q;

    always_comb
    begin
        pc_next = ProdW'(lane_in.p) * ProdW'(cos_val);
        qs_next = ProdW'(lane_in.q) * ProdW'(sin_val);
        ps_next = ProdW'(lane_in.p) * ProdW'(sin_val);
        qc_next = ProdW'(lane_in.q) * ProdW'(cos_val);
    end

    always_comb
    begin
        sum_p              = SumW'(pc_reg) - SumW'(qs_reg);
        sum_q              = SumW'(ps_reg) + SumW'(qc_reg);
        sum_lane_next.p    = round_sat(sum_p);
        sum_lane_next.q    = round_sat(sum_q);
        sum_lane_next.r    = mul_r_reg;
        sum_lane_next.last = mul_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg       <= pc_next;
        qs_reg       <= qs_next;
        ps_reg       <= ps_next;
        qc_reg       <= qc_next;
        mul_r_reg    <= lane_in.r;
        mul_last_reg <= lane_in.last;
        sum_lane_reg <= sum_lane_next;
    end

    assign out_valid = sum_valid_reg;
    assign lane_out  = sum_lane_reg;

    a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##2 out_valid)
        else $error("item valid lost in rotation stage");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 2))
        else $error("rotation stage produced an item that never entered");

    a_pass_r: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lane_out.r == $past(lane_in.r, 2)))
        else $error("pass-through coordinate out of step with its item");

    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lane_out.last == $past(lane_in.last, 2)))
        else $error("last flag out of step with its item");

endmodule

`default_nettype wire

// ----- tb/vrx_rotate_checker.sv -----
`timescale 1ns / 100ps
// Result checker for vertex_rotate_xyz_unit: keeps its own copy of the trig registers,
// predicts each rotated vertex and compares results in order. Depends on vrx_pkg.

module vrx_rotate_checker #(
    parameter int FRAC_BITS = vrx_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  vrx_pkg::vertex_t                    vertex,
    input  logic                                result_valid,
    input  vrx_pkg::result_t                    result,
    input  logic                                cfg_wr_en,
    input  logic [vrx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vrx_pkg::TRIG_WIDTH-1:0]      cfg_wdata,
    output int                                  mismatches,
    output int                                  in_flight
);
    import vrx_pkg::*;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam logic signed [TRIG_WIDTH-1:0] UNITY = TRIG_WIDTH'(1 <<< FRAC_BITS);
    localparam int MAX_PRINTED = 40;

    trig_cfg_t trig;
    result_t   rotated_q[$];
    result_t   want;
    int        result_count = 0;

    // (a*ca + b*cb) / 2^FRAC_BITS, round half up, clamp to coordinate range
    function automatic longint rotate_term(longint a, longint ca, longint b, longint cb);
        longint acc;
        acc = a * ca + b * cb + (longint'(1) <<< (FRAC_BITS - 1));
        acc = acc >>> FRAC_BITS;
        if (acc > COORD_HI)
            return COORD_HI;
        if (acc < COORD_LO)
            return COORD_LO;
        return acc;
    endfunction

    function automatic result_t rotate_vertex(vertex_t v, trig_cfg_t t);
        longint  x, y, z, cx, sx, cy, sy, cz, sz;
        longint  y_a, z_a, x_b, z_b;
        result_t r;
        x  = longint'(v.x_in);
        y  = longint'(v.y_in);
        z  = longint'(v.z_in);
        cx = longint'(t.cos_x);
        sx = longint'(t.sin_x);
        cy = longint'(t.cos_y);
        sy = longint'(t.sin_y);
        cz = longint'(t.cos_z);
        sz = longint'(t.sin_z);
        y_a = rotate_term(y, cx, z, -sx);
        z_a = rotate_term(y, sx, z, cx);
        x_b = rotate_term(x, cy, z_a, sy);
        z_b = rotate_term(z_a, cy, x, -sy);
        r.x_out    = COORD_WIDTH'(rotate_term(x_b, cz, y_a, -sz));
        r.y_out    = COORD_WIDTH'(rotate_term(x_b, sz, y_a, cz));
        r.z_out    = COORD_WIDTH'(z_b);
        r.last_out = v.last_vertex;
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint exp_val);
        if (got != exp_val)
            report($sformatf("result %0d %s: got %0d, want %0d",
                             result_count, name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig = '{cos_x: UNITY, sin_x: '0, cos_y: UNITY, sin_y: '0,
                     cos_z: UNITY, sin_z: '0};
            rotated_q.delete();
            in_flight = 0;
        end
        else
        begin
            // pop before push so a same-edge item never pairs with this result
            if (result_valid)
            begin
                if (rotated_q.size() == 0)
                    report($sformatf("result %0d arrived with no item outstanding",
                                     result_count));
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("x_out", longint'(result.x_out), longint'(want.x_out));
                    check_field("y_out", longint'(result.y_out), longint'(want.y_out));
                    check_field("z_out", longint'(result.z_out), longint'(want.z_out));
                    check_field("last_out", longint'(result.last_out),
                                longint'(want.last_out));
                end
                result_count++;
            end
            if (start && !busy)
                rotated_q.push_back(rotate_vertex(vertex, trig));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_COS_X: trig.cos_x = cfg_wdata;
                    REG_SIN_X: trig.sin_x = cfg_wdata;
                    REG_COS_Y: trig.cos_y = cfg_wdata;
                    REG_SIN_Y: trig.sin_y = cfg_wdata;
                    REG_COS_Z: trig.cos_z = cfg_wdata;
                    REG_SIN_Z: trig.sin_z = cfg_wdata;
                    default: ;
                endcase
            end
            in_flight = rotated_q.size();
        end
    end

endmodule

// ----- tb/vertex_rotate_xyz_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the vertex_rotate_xyz_unit testbench: clock, reset, vertex and register stimulus,
// watchdog and verdict. Depends on vrx_pkg, vrx_rotate_checker and the unit itself.

module vertex_rotate_xyz_unit_test;
    import vrx_pkg::*;

    typedef enum logic [1:0] {TRIG_IDENTITY, TRIG_ANGLE, TRIG_RAW, TRIG_CORNER} trig_mode_t;

    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_HI = 3'd7;
    localparam logic signed [TRIG_WIDTH-1:0] UNITY     = 16'sd16384;
    localparam logic signed [TRIG_WIDTH-1:0] HALF      = 16'sd8192;
    localparam logic signed [TRIG_WIDTH-1:0] TRIG_MAX  = 16'sh7fff;
    localparam logic signed [TRIG_WIDTH-1:0] TRIG_MIN  = 16'sh8000;
    localparam logic [COORD_WIDTH-1:0]       COORD_MAX = 32'h7fff_ffff;
    localparam logic [COORD_WIDTH-1:0]       COORD_MIN = 32'h8000_0000;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    vertex_t                    vertex;
    logic                       result_valid;
    result_t                    result;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [TRIG_WIDTH-1:0]      cfg_wdata;
    int                         mismatches;
    int                         in_flight;
    int                         idle_cycles = 0;
    int                         burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    vertex_rotate_xyz_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    vrx_rotate_checker rotation_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_wr_en)
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic vertex_t make_vertex(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                                            logic [COORD_WIDTH-1:0] z, logic last);
        vertex_t v;
        v.x_in        = x;
        v.y_in        = y;
        v.z_in        = z;
        v.last_vertex = last;
        return v;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        if (sel < 7)
            return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        if (sel < 9)
            return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        case ($urandom_range(0, 4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [TRIG_WIDTH-1:0] trig_value(trig_mode_t mode);
        int v;
        case (mode)
            TRIG_ANGLE:
            begin
                v = int'($urandom_range(0, 32768)) - 16384;
                return v[TRIG_WIDTH-1:0];
            end
            TRIG_RAW:
                return TRIG_WIDTH'($urandom);
            TRIG_CORNER:
            begin
                case ($urandom_range(0, 4))
                    0:       return UNITY;
                    1:       return -UNITY;
                    2:       return '0;
                    3:       return TRIG_MAX;
                    default: return TRIG_MIN;
                endcase
            end
            default:
                return UNITY;
        endcase
    endfunction

    function automatic trig_cfg_t pick_trig(trig_mode_t mode);
        trig_cfg_t t;
        if (mode == TRIG_IDENTITY)
            t = '{cos_x: UNITY, sin_x: '0, cos_y: UNITY, sin_y: '0, cos_z: UNITY, sin_z: '0};
        else
            t = '{cos_x: trig_value(mode), sin_x: trig_value(mode),
                  cos_y: trig_value(mode), sin_y: trig_value(mode),
                  cos_z: trig_value(mode), sin_z: trig_value(mode)};
        return t;
    endfunction

    // leaves start high; the caller lowers it or offers the next item
    task automatic push_vertex(input vertex_t v);
        vertex <= v;
        start  <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (in_flight != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [TRIG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // spare indexes get junk; the unit must ignore it
    task automatic load_trig(input trig_cfg_t t);
        write_reg(REG_COS_X, t.cos_x);
        write_reg(REG_SIN_X, t.sin_x);
        write_reg(REG_COS_Y, t.cos_y);
        write_reg(REG_SIN_Y, t.sin_y);
        write_reg(REG_COS_Z, t.cos_z);
        write_reg(REG_SIN_Z, t.sin_z);
        write_reg(IDX_SPARE_LO, TRIG_WIDTH'($urandom));
        write_reg(IDX_SPARE_HI, TRIG_WIDTH'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(input int count);
        int gap;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                         : $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            push_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                    $urandom_range(0, 7) == 0));
            burst_left--;
        end
    endtask

    initial
    begin
        int sent;
        int count;
        trig_mode_t mode;

        rst_n     = 1'b0;
        start     = 1'b0;
        vertex    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values must give the identity
        push_vertex(make_vertex('0, '0, '0, 1'b0));
        push_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        push_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        push_vertex(make_vertex(COORD_MAX, COORD_MIN, '1, 1'b0));
        push_vertex(make_vertex(32'd1, '1, 32'h0001_8000, 1'b1));
        push_vertex(make_vertex(32'h0000_ffff, 32'hffff_0001, 32'h1234_5678, 1'b0));
        wait_drained();

        // half scale about Z: odd coordinates land on exact ties
        load_trig('{cos_x: UNITY, sin_x: '0, cos_y: UNITY, sin_y: '0,
                    cos_z: HALF, sin_z: '0});
        push_vertex(make_vertex(32'd1, 32'd1, '0, 1'b0));
        push_vertex(make_vertex('1, '1, '0, 1'b0));
        push_vertex(make_vertex(32'd3, -32'sd3, '0, 1'b0));
        push_vertex(make_vertex(-32'sd3, 32'd3, '0, 1'b1));
        push_vertex(make_vertex(COORD_MIN, COORD_MAX, '0, 1'b0));
        push_vertex(make_vertex(COORD_MAX, COORD_MIN, '1, 1'b0));
        wait_drained();

        // gains beyond 1.0 and the most negative sine: saturation in every stage
        load_trig('{cos_x: TRIG_MAX, sin_x: TRIG_MIN, cos_y: TRIG_MAX, sin_y: TRIG_MIN,
                    cos_z: TRIG_MAX, sin_z: TRIG_MIN});
        push_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        push_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
        push_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1));
        push_vertex(make_vertex(COORD_MIN, COORD_MAX, '0, 1'b0));
        push_vertex(make_vertex('0, '0, '0, 1'b1));
        push_vertex(make_vertex(32'd1, '1, 32'd1, 1'b0));
        wait_drained();

        // quarter turn about each axis
        load_trig('{cos_x: '0, sin_x: UNITY, cos_y: '0, sin_y: UNITY,
                    cos_z: '0, sin_z: UNITY});
        push_vertex(make_vertex(32'h0001_0000, '0, '0, 1'b0));
        push_vertex(make_vertex('0, 32'h0001_0000, '0, 1'b0));
        push_vertex(make_vertex('0, '0, 32'h0001_0000, 1'b1));
        push_vertex(make_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0));
        wait_drained();

        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            mode = trig_mode_t'(phase % 4);
            load_trig(pick_trig(mode));
            count = $urandom_range(80, 170);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            send_random(count);
            sent += count;
            wait_drained();
        end

        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vrx_pkg.sv
rtl/vrx_cfg_regs.sv
rtl/vrx_rot_stage.sv
rtl/vertex_rotate_xyz_unit.sv
tb/vrx_rotate_checker.sv
tb/vertex_rotate_xyz_unit_test.sv
